### rtl/core/srpg_pkg.sv
package srpg_pkg;

    localparam int FREQ_W     = 15;
    localparam int HOLD_W     = 20;
    localparam int PERIOD_W   = 20;
    localparam int HALF_W     = PERIOD_W - 1;
    localparam int DIV_CNT_W  = $clog2(PERIOD_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int TICK_RATE_HZ_DEF     = 1000000;
    localparam int MAX_FREQ_HZ_DEF      = 20000;
    localparam int MIN_PERIOD_TICKS_DEF = 10;

    localparam logic [FREQ_W-1:0]   START_FREQ_RST  = 15'd100;
    localparam logic [FREQ_W-1:0]   TARGET_FREQ_RST = 15'd800;
    localparam logic [FREQ_W-1:0]   ACCEL_STEP_RST  = 15'd20;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST  = 20'd30000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 20'd10000;
    localparam logic [HALF_W-1:0]   HALF_RST        = 19'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_START_FREQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FREQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd4;

    typedef struct packed {
        logic accept;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/core/srpg_div.sv
module srpg_div #(
    parameter int TICK_RATE_HZ = srpg_pkg::TICK_RATE_HZ_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [srpg_pkg::FREQ_W-1:0]   divisor,
    output logic                          done,
    output logic [srpg_pkg::PERIOD_W-1:0] quotient
);

    localparam int FW = srpg_pkg::FREQ_W;
    localparam int PW = srpg_pkg::PERIOD_W;
    localparam logic [PW-1:0] DIVIDEND = PW'(TICK_RATE_HZ);
    localparam logic [srpg_pkg::DIV_CNT_W-1:0] LAST_CNT = srpg_pkg::DIV_CNT_W'(PW - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [srpg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [FW-1:0]                 rem_reg;
    logic [PW-1:0]                 quo_reg;
    logic [FW-1:0]                 divisor_reg;
    logic [FW:0]                   rem_sh;
    logic [FW:0]                   diff;
    logic                          ge;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, quo_reg[PW-1]};
    assign ge     = rem_sh >= {1'b0, divisor_reg};
    assign diff   = rem_sh - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= DIVIDEND;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[FW-1:0] : rem_sh[FW-1:0];
            quo_reg <= {quo_reg[PW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/srpg_datapath.sv
module srpg_datapath #(
    parameter int TICK_RATE_HZ     = srpg_pkg::TICK_RATE_HZ_DEF,
    parameter int MAX_FREQ_HZ      = srpg_pkg::MAX_FREQ_HZ_DEF,
    parameter int MIN_PERIOD_TICKS = srpg_pkg::MIN_PERIOD_TICKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srpg_pkg::ctrl_cmd_t             cmd,
    output srpg_pkg::ctrl_status_t          status,
    input  logic                            start_req,
    input  logic                            cfg_valid,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic                            step_out,
    output logic                            dir_out,
    output logic [srpg_pkg::FREQ_W-1:0]     current_freq,
    output logic                            at_speed
);

    localparam int FW = srpg_pkg::FREQ_W;
    localparam int HW = srpg_pkg::HOLD_W;
    localparam int PW = srpg_pkg::PERIOD_W;
    localparam logic [FW+1:0] MAX_F = (FW+2)'(MAX_FREQ_HZ);
    localparam logic [PW-1:0] MIN_P = PW'(MIN_PERIOD_TICKS);

    // configuration
    logic [FW-1:0] start_freq_reg;
    logic [FW-1:0] target_freq_reg;
    logic [FW-1:0] accel_step_reg;
    logic [HW-1:0] hold_ticks_reg;
    logic          direction_reg;

    // motion state
    logic                        running_reg, running_next;
    logic                        ramping_reg, ramping_next;
    logic [HW-1:0]               hold_reg, hold_next;
    logic [FW-1:0]               ramp_reg, ramp_next;
    logic [FW-1:0]               freq_now_reg;
    logic [FW-1:0]               freq_pend_reg;
    logic [PW-1:0]               period_reg;
    logic [srpg_pkg::HALF_W-1:0] half_reg;
    logic [PW-1:0]               tick_reg;

    // result register
    logic          out_valid_reg;
    logic          step_out_reg;
    logic          dir_out_reg;
    logic [FW-1:0] current_freq_reg;
    logic          at_speed_reg;

    logic          apply;
    logic [FW-1:0] freq_sel;
    logic [FW-1:0] freq_clamp;
    logic [HW-1:0] hold_inc;
    logic [FW:0]   ramp_sum;
    logic          div_done;
    logic [PW-1:0] quotient;
    logic [PW-1:0] period_new;
    logic [PW:0]   tick_inc;
    logic          step_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_freq_reg  <= srpg_pkg::START_FREQ_RST;
            target_freq_reg <= srpg_pkg::TARGET_FREQ_RST;
            accel_step_reg  <= srpg_pkg::ACCEL_STEP_RST;
            hold_ticks_reg  <= srpg_pkg::HOLD_TICKS_RST;
            direction_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                srpg_pkg::REG_START_FREQ:  start_freq_reg  <= cfg_data[FW-1:0];
                srpg_pkg::REG_TARGET_FREQ: target_freq_reg <= cfg_data[FW-1:0];
                srpg_pkg::REG_ACCEL_STEP:  accel_step_reg  <= cfg_data[FW-1:0];
                srpg_pkg::REG_HOLD_TICKS:  hold_ticks_reg  <= cfg_data[HW-1:0];
                srpg_pkg::REG_DIRECTION:   direction_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign hold_inc = hold_reg + 1'b1;
    assign ramp_sum = {1'b0, ramp_reg} + {1'b0, accel_step_reg};

    // start request or end of hold interval
    always_comb
    begin
        running_next = running_reg;
        ramping_next = ramping_reg;
        hold_next    = hold_reg;
        ramp_next    = ramp_reg;
        apply        = 1'b0;
        freq_sel     = target_freq_reg;
        if (start_req)
        begin
            running_next = 1'b1;
            hold_next    = '0;
            apply        = 1'b1;
            if (start_freq_reg <= target_freq_reg)
            begin
                ramp_next    = start_freq_reg;
                ramping_next = 1'b1;
                freq_sel     = start_freq_reg;
            end
            else
            begin
                ramp_next    = target_freq_reg;
                ramping_next = 1'b0;
            end
        end
        else if (running_reg && ramping_reg)
        begin
            hold_next = hold_inc;
            if (hold_inc >= hold_ticks_reg)
            begin
                hold_next = '0;
                apply     = 1'b1;
                if (ramp_sum <= {1'b0, target_freq_reg})
                begin
                    ramp_next = ramp_sum[FW-1:0];
                    freq_sel  = ramp_sum[FW-1:0];
                end
                else
                begin
                    ramping_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (freq_sel == '0)
            freq_clamp = FW'(1);
        else if ({2'b00, freq_sel} > MAX_F)
            freq_clamp = MAX_F[FW-1:0];
        else
            freq_clamp = freq_sel;
    end

    srpg_div #(
        .TICK_RATE_HZ (TICK_RATE_HZ)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept && apply),
        .divisor  (freq_clamp),
        .done     (div_done),
        .quotient (quotient)
    );

    assign period_new = (quotient < MIN_P) ? MIN_P : quotient;
    assign tick_inc   = {1'b0, tick_reg} + 1'b1;
    assign step_now   = running_reg && (tick_reg < {1'b0, half_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            ramping_reg   <= 1'b0;
            hold_reg      <= '0;
            ramp_reg      <= '0;
            freq_now_reg  <= '0;
            freq_pend_reg <= '0;
            period_reg    <= srpg_pkg::PERIOD_RST;
            half_reg      <= srpg_pkg::HALF_RST;
            tick_reg      <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                running_reg   <= running_next;
                ramping_reg   <= ramping_next;
                hold_reg      <= hold_next;
                ramp_reg      <= ramp_next;
                freq_pend_reg <= freq_clamp;
            end
            if (div_done)
            begin
                freq_now_reg <= freq_pend_reg;
                period_reg   <= period_new;
                half_reg     <= period_new[PW-1:1];
                tick_reg     <= '0;
            end
            else if (cmd.emit && running_reg)
            begin
                // wrap after the last tick of the period
                if (tick_inc >= {1'b0, period_reg})
                    tick_reg <= '0;
                else
                    tick_reg <= tick_inc[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            step_out_reg     <= step_now;
            dir_out_reg      <= direction_reg;
            current_freq_reg <= freq_now_reg;
            at_speed_reg     <= running_reg && !ramping_reg;
        end
    end

    assign status.need_div = apply;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign step_out     = step_out_reg;
    assign dir_out      = dir_out_reg;
    assign current_freq = current_freq_reg;
    assign at_speed     = at_speed_reg;

endmodule

### rtl/core/srpg_ctrl.sv
module srpg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  srpg_pkg::ctrl_status_t status,
    output srpg_pkg::ctrl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = status.need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the result register can take the transfer
                cmd.emit = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && status.need_div |=> state_reg == ST_DIV)
        else $error("period update did not enter divide state");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == ST_IDLE && !in_stall)
        else $error("controller not idle after result load");

endmodule

### rtl/core/stepper_ramp_pulse_generator_core.sv
// Stepper ramp pulse generator.
// Input channel (in_valid / in_stall, start_req): one transfer is one tick of
// the step timer. start_req high starts or restarts the acceleration ramp.
// Output channel (out_valid / out_stall): exactly one result per tick, in
// order: step_out level, dir_out, current_freq in Hz and at_speed.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; index 0 start_freq, 1 target_freq, 2 accel_step,
// 3 ramp_hold_ticks, 4 direction. Write only while the block is idle.
// Timing: a tick that keeps the frequency passes from the idle state to the
// emit state, which loads the result register once the output register is
// free; the controller then returns to idle and takes the next tick. A tick
// that changes the frequency first runs the period divider in the divide
// state, one quotient bit per cycle, and then goes to the emit state.
// One tick is in work at a time; the next tick is taken once the result is
// loaded, while that result may still wait in the output register.
// Reset: configuration and motion registers take their defaults and the
// motor stops; the result data is not reset. A stalled receiver holds the
// result; the controller waits with it until the output register is free.
module stepper_ramp_pulse_generator_core #(
    parameter int TICK_RATE_HZ     = srpg_pkg::TICK_RATE_HZ_DEF,
    parameter int MAX_FREQ_HZ      = srpg_pkg::MAX_FREQ_HZ_DEF,
    parameter int MIN_PERIOD_TICKS = srpg_pkg::MIN_PERIOD_TICKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_req,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            step_out,
    output logic                            dir_out,
    output logic [srpg_pkg::FREQ_W-1:0]     current_freq,
    output logic                            at_speed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    srpg_pkg::ctrl_cmd_t    cmd;
    srpg_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    srpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    srpg_datapath #(
        .TICK_RATE_HZ     (TICK_RATE_HZ),
        .MAX_FREQ_HZ      (MAX_FREQ_HZ),
        .MIN_PERIOD_TICKS (MIN_PERIOD_TICKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_req    (start_req),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .step_out     (step_out),
        .dir_out      (dir_out),
        .current_freq (current_freq),
        .at_speed     (at_speed)
    );

endmodule
